// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent checks shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/mtb_pkg.sv
// ----------------------------------------------------------------------------
// mtb_pkg
// Types and fixed constants of the morph target blender.
// ----------------------------------------------------------------------------
package mtb_pkg;

  // Field widths.
  localparam int MODE_W    = 2;
  localparam int TIDX_W    = 3;
  localparam int ELEM_W    = 12;
  localparam int VAL_W     = 32;
  localparam int WGT_W     = 16;
  localparam int LEN_W     = 13;
  localparam int STAT_W    = 2;
  localparam int VCNT_W    = 11;
  localparam int TCNT_W    = 4;
  localparam int PROD_W    = VAL_W + WGT_W;
  localparam int IN_DATA_W = 48;
  localparam int RND_SHIFT = 12;

  // Components per vertex.
  localparam int AXES = 3;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WEIGHT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_TARGET  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_ELEMENT = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_TARGET_COUNT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_ROUND,
    S_DONE
  } state_t;

endpackage

// File: rtl/morph_target_blend.sv
// ----------------------------------------------------------------------------
// morph_target_blend
// Morph target store with on-demand weighted blend of one vertex component.
// ----------------------------------------------------------------------------
// The block takes one request at a time. A load or weight request passes
// through the done state to the result register. A blended read walks n
// targets, where n is target_count limited to MAX_TARGETS: the single
// port of the target store delivers one target's element per cycle into a
// multiply-accumulate pipeline, which then drains before the sum is
// rounded and saturated. A read that is out of range, or one with no
// active target, goes straight to the done state. The result register lets
// the next request be accepted while a finished result still waits on the output.
module morph_target_blend
  import mtb_pkg::*;
#(
  parameter int MAX_TARGETS  = 8,
  parameter int MAX_ELEMENTS = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  // Request stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: target_index[2:0], element_index[14:3], value[46:15], zero[47].
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  // tuser: mode[1:0].
  input  logic [MODE_W-1:0]    s_axis_tuser,
  // tlast: last_element.
  input  logic                 s_axis_tlast,
  // Result stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: blended_value[31:0].
  output logic [VAL_W-1:0]     m_axis_tdata,
  // tuser: status[1:0].
  output logic [STAT_W-1:0]    m_axis_tuser,
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  `include "assert_macros.svh"

  localparam int TGT_W  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNT_W  = $clog2(MAX_TARGETS + 1);
  localparam int DEPTH  = MAX_TARGETS * MAX_ELEMENTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ACC_W  = PROD_W + TGT_W + 1;
  localparam int RND_W  = ACC_W + 1 - RND_SHIFT;

  localparam logic signed [RND_W-1:0] SAT_HI = {{(RND_W - VAL_W){1'b0}}, 32'h7fffffff};
  localparam logic signed [RND_W-1:0] SAT_LO = {{(RND_W - VAL_W){1'b1}}, 32'h80000000};

  // Configuration registers.
  logic [VCNT_W-1:0] vertex_count;
  logic [TCNT_W-1:0] target_count;

  // Per-target length and weight.
  logic        [LEN_W-1:0] target_length [MAX_TARGETS];
  logic signed [WGT_W-1:0] target_weight [MAX_TARGETS];

  // Target store.
  logic [VAL_W-1:0]  target_store [DEPTH];
  logic [VAL_W-1:0]  mem_rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;

  // Control.
  state_t state, state_next;
  logic   accept;
  logic   issue;
  logic   out_free;

  // Walk over the targets of one read.
  logic [CNT_W-1:0]  walk_cnt;
  logic [CNT_W-1:0]  walk_total;
  logic [ADDR_W-1:0] walk_addr;
  logic [ELEM_W-1:0] read_elem;
  logic [TGT_W-1:0]  walk_idx;

  // Multiply-accumulate pipeline.
  logic                     s1_valid;
  logic                     s1_use;
  logic signed [WGT_W-1:0]  s1_weight;
  logic                     s2_valid;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [ACC_W-1:0]  acc;

  // Rounding and saturation.
  logic signed [ACC_W:0]   biased;
  logic signed [RND_W-1:0] rounded;
  logic        [VAL_W-1:0] sat_value;

  // Pending result.
  logic [VAL_W-1:0]  res_value;
  logic [STAT_W-1:0] res_status;

  // Request fields.
  logic [TIDX_W-1:0] in_tgt;
  logic [ELEM_W-1:0] in_elem;
  logic [VAL_W-1:0]  in_value;
  logic [TGT_W-1:0]  in_idx;
  logic              tgt_ok;
  logic              elem_ok;
  logic              wgt_ok;
  logic              read_ok;
  logic [LEN_W-1:0]  elem_limit;
  logic [CNT_W-1:0]  active_cnt;

  assign in_tgt   = s_axis_tdata[2:0];
  assign in_elem  = s_axis_tdata[14:3];
  assign in_value = s_axis_tdata[46:15];
  assign in_idx   = TGT_W'(in_tgt);

  // Request checks.
  assign elem_limit = LEN_W'(AXES) * LEN_W'(vertex_count);
  assign tgt_ok     = 32'(in_tgt) < MAX_TARGETS;
  assign elem_ok    = 32'(in_elem) < MAX_ELEMENTS;
  assign wgt_ok     = tgt_ok && ({1'b0, in_tgt} < target_count);
  assign read_ok    = elem_ok && ({1'b0, in_elem} < elem_limit);
  assign active_cnt = (32'(target_count) > MAX_TARGETS) ? CNT_W'(MAX_TARGETS)
                                                         : CNT_W'(target_count);

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Store writes happen at acceptance of a valid load.
  assign mem_we    = accept && (s_axis_tuser == MODE_LOAD) && tgt_ok && elem_ok;
  assign mem_waddr = ADDR_W'(in_tgt) * ADDR_W'(MAX_ELEMENTS) + ADDR_W'(in_elem);

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TARGET_COUNT) ? {28'b0, target_count}
                                                 : {21'b0, vertex_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      target_count <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_VERTEX_COUNT) begin
        vertex_count <= pwdata[VCNT_W-1:0];
      end else begin
        target_count <= pwdata[TCNT_W-1:0];
      end
    end
  end

  // Target store, one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      target_store[mem_waddr] <= in_value;
    end
    if (issue) begin
      mem_rdata <= target_store[walk_addr];
    end
  end

  // Target lengths and weights.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TARGETS; i++) begin
        target_length[i] <= '0;
        target_weight[i] <= '0;
      end
    end else if (accept) begin
      if (mem_we && s_axis_tlast) begin
        target_length[in_idx] <= LEN_W'(in_elem) + LEN_W'(1);
      end
      if ((s_axis_tuser == MODE_WEIGHT) && wgt_ok) begin
        target_weight[in_idx] <= in_value[WGT_W-1:0];
      end
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake. In idle the request side is always ready, so
  // a valid request is accepted there.
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if ((s_axis_tuser == MODE_READ) && read_ok && (active_cnt != '0)) begin
            state_next = S_WALK;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_WALK: begin
        issue = 1'b1;
        if (walk_cnt + CNT_W'(1) == walk_total) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (s2_valid && !s1_valid) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Walk control and the pending result.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_value  <= '0;
      res_status <= ST_OK;
      walk_cnt   <= '0;
      walk_total <= active_cnt;
      walk_addr  <= ADDR_W'(in_elem);
      read_elem  <= in_elem;
      case (s_axis_tuser)
        MODE_LOAD: begin
          if (!tgt_ok) begin
            res_status <= ST_BAD_TARGET;
          end else if (!elem_ok) begin
            res_status <= ST_BAD_ELEMENT;
          end
        end
        MODE_WEIGHT: begin
          if (!wgt_ok) begin
            res_status <= ST_BAD_TARGET;
          end
        end
        MODE_READ: begin
          if (!read_ok) begin
            res_status <= ST_BAD_ELEMENT;
          end
        end
        default: begin
          res_status <= ST_OK;
        end
      endcase
    end else if (issue) begin
      walk_cnt  <= walk_cnt + CNT_W'(1);
      walk_addr <= walk_addr + ADDR_W'(MAX_ELEMENTS);
    end else if (state == S_ROUND) begin
      res_value <= sat_value;
    end
  end

  assign walk_idx = walk_cnt[TGT_W-1:0];

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  // A target adds nothing at or past its length.
  always_comb begin
    prod_next = $signed(mem_rdata) * s1_weight;
    if (!s1_use) begin
      prod_next = '0;
    end
  end

  // Multiply-accumulate datapath.
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_weight <= target_weight[walk_idx];
      s1_use    <= {1'b0, read_elem} < target_length[walk_idx];
    end
    if (s1_valid) begin
      prod <= prod_next;
    end
    if (accept) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // Round to nearest, ties up, then saturate to 32 bits.
  always_comb begin
    biased  = {acc[ACC_W-1], acc} + (ACC_W + 1)'(2048);
    rounded = biased[ACC_W:RND_SHIFT];
    if (rounded > SAT_HI) begin
      sat_value = 32'h7fffffff;
    end else if (rounded < SAT_LO) begin
      sat_value = 32'h80000000;
    end else begin
      sat_value = rounded[VAL_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      m_axis_tdata <= res_value;
      m_axis_tuser <= res_status;
    end
  end

  // Checks on the sequencing of store accesses and the MAC pipeline.
  `ASSERT_NEVER(a_no_write_in_walk, mem_we && (state != S_IDLE), "store write outside idle")
  `ASSERT_CLK(a_walk_in_range, (state == S_WALK) |-> (walk_cnt < walk_total), "walk overrun")
  `ASSERT_CLK(a_round_drained, (state == S_ROUND) |-> (!s1_valid && !s2_valid), "round before drain")
  `ASSERT_CLK(a_pipe_in_walk, s2_valid |-> ((state == S_WALK) || (state == S_DRAIN)), "stray MAC data")

endmodule

// File: tb/mtb_result_check.sv
// ----------------------------------------------------------------------------
// mtb_result_check
// Watches the request, result and configuration ports of the morph target
// blender, predicts every result from its own copy of the target store,
// lengths, weights and registers, and compares the results field by field.
// ----------------------------------------------------------------------------
module mtb_result_check
  import mtb_pkg::*;
#(
  parameter int MAX_TARGETS  = 8,
  parameter int MAX_ELEMENTS = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  // tdata: target_index[2:0], element_index[14:3], value[46:15], zero[47].
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  // tuser: mode[1:0].
  input  logic [MODE_W-1:0]    s_axis_tuser,
  input  logic                 s_axis_tlast,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: blended_value[31:0].
  input  logic [VAL_W-1:0]     m_axis_tdata,
  // tuser: status[1:0].
  input  logic [STAT_W-1:0]    m_axis_tuser,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  input  logic                 pready,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SAT_HI = 2147483647;
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef struct packed {
    logic [VAL_W-1:0]  blended;
    logic [STAT_W-1:0] status;
  } blend_reply_t;

  // Shadow copy of the block's state and registers.
  logic [VAL_W-1:0]        target_mem [MAX_TARGETS*MAX_ELEMENTS];
  logic [LEN_W-1:0]        target_len [MAX_TARGETS];
  logic signed [WGT_W-1:0] target_wgt [MAX_TARGETS];
  logic [VCNT_W-1:0]       vertex_count;
  logic [TCNT_W-1:0]       target_count;
  blend_reply_t            owed_results [$];

  // Weighted sum over the active targets with Q3.12 weights, rounded half up
  // to the scale of the stored values and saturated to 32 bits.
  function automatic logic [VAL_W-1:0] blend_component(input logic [ELEM_W-1:0] elem);
    longint acc;
    longint scaled;
    int     active;
    acc    = 0;
    active = (target_count > MAX_TARGETS) ? MAX_TARGETS : target_count;
    for (int t = 0; t < active; t++) begin
      if (elem < target_len[t]) begin
        acc += longint'($signed(target_mem[t*MAX_ELEMENTS + elem])) *
               longint'(target_wgt[t]);
      end
    end
    scaled = (acc + (longint'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
    if (scaled > SAT_HI) scaled = SAT_HI;
    if (scaled < SAT_LO) scaled = SAT_LO;
    return scaled[VAL_W-1:0];
  endfunction

  // Applies one request to the shadow state and returns the result it owes.
  function automatic blend_reply_t apply_request(input logic [MODE_W-1:0] op,
                                                 input logic [TIDX_W-1:0] tgt,
                                                 input logic [ELEM_W-1:0] elem,
                                                 input logic [VAL_W-1:0]  val,
                                                 input logic              last);
    blend_reply_t reply;
    reply.blended = '0;
    reply.status  = ST_OK;
    case (op)
      MODE_LOAD: begin
        if (tgt >= MAX_TARGETS) begin
          reply.status = ST_BAD_TARGET;
        end else if (elem >= MAX_ELEMENTS) begin
          reply.status = ST_BAD_ELEMENT;
        end else begin
          target_mem[tgt*MAX_ELEMENTS + elem] = val;
          if (last) target_len[tgt] = LEN_W'(elem) + LEN_W'(1);
        end
      end
      MODE_WEIGHT: begin
        if (tgt >= target_count || tgt >= MAX_TARGETS) reply.status = ST_BAD_TARGET;
        else target_wgt[tgt] = val[WGT_W-1:0];
      end
      MODE_READ: begin
        if (elem >= AXES * vertex_count || elem >= MAX_ELEMENTS) begin
          reply.status = ST_BAD_ELEMENT;
        end else begin
          reply.blended = blend_component(elem);
        end
      end
      default: begin
        // The spare mode leaves everything alone.
      end
    endcase
    return reply;
  endfunction

  // Results are checked before the request of the same edge is predicted,
  // since a result can never belong to a request accepted at that edge.
  always @(posedge clk) begin : watch
    blend_reply_t want;
    if (rst) begin
      for (int t = 0; t < MAX_TARGETS; t++) begin
        target_len[t] = '0;
        target_wgt[t] = '0;
      end
      vertex_count = '0;
      target_count = '0;
      owed_results.delete();
      errors = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result with no request waiting: value %h status %h",
                   $time, m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          want = owed_results.pop_front();
          if (m_axis_tdata !== want.blended) begin
            $display("%0t: blended_value expected %h, got %h",
                     $time, want.blended, m_axis_tdata);
            errors++;
          end
          if (m_axis_tuser !== want.status) begin
            $display("%0t: status expected %0d, got %0d",
                     $time, want.status, m_axis_tuser);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        owed_results.push_back(apply_request(s_axis_tuser, s_axis_tdata[2:0],
                                             s_axis_tdata[14:3], s_axis_tdata[46:15],
                                             s_axis_tlast));
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_VERTEX_COUNT: vertex_count = pwdata[VCNT_W-1:0];
          REG_TARGET_COUNT: target_count = pwdata[TCNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending = owed_results.size();
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the morph target blender: a directed pass over value and
// weight extremes, saturation, range errors and the spare mode, then random
// phases of target loads, weight updates and blended reads under several
// register settings and handshake stall patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtb_pkg::*;

  localparam int              NUM_TARGETS   = 8;
  localparam int              NUM_ELEMENTS  = 4096;
  localparam int              RESET_CYCLES  = 10;
  localparam int              SETTLE_CYCLES = 16;
  localparam int              STALL_LIMIT   = 2000;
  localparam int              PHASES        = 12;
  localparam int              PHASE_ITEMS   = 80;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // tdata: target_index[2:0], element_index[14:3], value[46:15], zero[47].
  logic [IN_DATA_W-1:0] s_axis_tdata;
  // tuser: mode[1:0].
  logic [MODE_W-1:0]    s_axis_tuser;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // tdata: blended_value[31:0].
  logic [VAL_W-1:0]     m_axis_tdata;
  // tuser: status[1:0].
  logic [STAT_W-1:0]    m_axis_tuser;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  int errors;
  int pending;
  int sent;
  int send_gap_pct;
  int recv_gap_pct;
  int vcount_now;

  // Which store entries hold data, and how long the written run from zero is.
  // A length flag is only sent when it covers written entries alone.
  bit loaded [NUM_TARGETS][NUM_ELEMENTS];
  int filled [NUM_TARGETS];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  morph_target_blend #(
    .MAX_TARGETS (NUM_TARGETS),
    .MAX_ELEMENTS(NUM_ELEMENTS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  mtb_result_check #(
    .MAX_TARGETS (NUM_TARGETS),
    .MAX_ELEMENTS(NUM_ELEMENTS)
  ) blend_check (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .errors       (errors),
    .pending      (pending)
  );

  // Result side back-pressure.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
  end

  // Ends the run when nothing moves on either stream for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // Sends one request, with random idle cycles ahead of it.
  task automatic push_request(input logic [MODE_W-1:0] op, input logic [TIDX_W-1:0] tgt,
                              input logic [ELEM_W-1:0] elem, input logic [VAL_W-1:0] val,
                              input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tdata  = {1'b0, val, elem, tgt};
    s_axis_tuser  = op;
    s_axis_tlast  = last;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  // Holds off the request stream until every result is back.
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic configure(input int vc, input int tc);
    wait_drained();
    apb_write(REG_VERTEX_COUNT, vc);
    apb_write(REG_TARGET_COUNT, tc);
    vcount_now = vc;
  endtask

  task automatic load_element(input int tgt, input int elem, input logic [31:0] val,
                              input bit want_last);
    loaded[tgt][elem] = 1'b1;
    while (filled[tgt] < NUM_ELEMENTS && loaded[tgt][filled[tgt]]) filled[tgt]++;
    push_request(MODE_LOAD, tgt[2:0], elem[11:0], val, want_last && elem < filled[tgt]);
  endtask

  task automatic set_weight(input int tgt, input logic [15:0] w);
    logic [31:0] word;
    word = $urandom();
    word[15:0] = w;
    push_request(MODE_WEIGHT, tgt[2:0], 12'($urandom_range(4095)), word, 1'($urandom()));
  endtask

  task automatic read_at(input int elem);
    push_request(MODE_READ, 3'($urandom()), elem[11:0], $urandom(), 1'($urandom()));
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'($signed($urandom_range(0, 65535)) - 32768) <<< 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h1000;
      3: return 16'($signed($urandom_range(0, 8191)) - 4096);
      default: return 16'($urandom());
    endcase
  endfunction

  // Mostly in range and near the loaded prefixes, sometimes past the mesh.
  task automatic read_component();
    int span;
    int elem;
    span = AXES * vcount_now;
    if (span == 0 || $urandom_range(99) < 12) begin
      elem = $urandom_range(span, NUM_ELEMENTS - 1);
    end else if ($urandom_range(99) < 65) begin
      elem = $urandom_range(0, ((span < 48) ? span : 48) - 1);
    end else begin
      elem = $urandom_range(0, span - 1);
    end
    read_at(elem);
  endtask

  task automatic load_target();
    int tgt;
    int len;
    tgt = $urandom_range(NUM_TARGETS - 1);
    len = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
    for (int e = 0; e < len; e++) load_element(tgt, e, pick_value(), e == len - 1);
  endtask

  initial begin : stimulus
    int phase_end;
    int vc;
    int tc;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_LOAD;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    sent          = 0;
    vcount_now    = 0;
    send_gap_pct  = 27;
    recv_gap_pct  = 69;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // Two short targets holding the value extremes, full-scale weights of
    // both signs, so the sums saturate in both directions.
    configure(2, 8);
    load_element(0, 0, 32'h7FFF_FFFF, 1'b0);
    load_element(0, 1, 32'h8000_0000, 1'b0);
    load_element(0, 2, 32'h0000_0001, 1'b1);
    load_element(1, 0, 32'h8000_0000, 1'b0);
    load_element(1, 1, 32'hFFFF_FFFF, 1'b1);
    set_weight(0, 16'h7FFF);
    set_weight(1, 16'h8000);
    set_weight(7, 16'h0800);
    read_at(0);
    read_at(1);
    read_at(2);
    read_at(4);
    read_at(5);
    read_at(6);
    read_at(NUM_ELEMENTS - 1);
    push_request(MODE_SPARE, 3'h7, 12'hFFF, 32'hFFFF_FFFF, 1'b1);

    // No active target and an empty mesh: weights and reads are refused.
    configure(0, 0);
    set_weight(0, 16'h1000);
    read_at(0);

    // Largest mesh, and a target count beyond the number of targets.
    configure(1365, 15);
    set_weight(7, 16'h7FFF);
    load_element(3, NUM_ELEMENTS - 1, 32'h5555_AAAA, 1'b0);
    read_at(0);
    read_at(AXES * 1365 - 1);
    read_at(AXES * 1365);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES / 3) begin
        send_gap_pct = 69;
        recv_gap_pct = 27;
      end else if (phase == 2 * PHASES / 3) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      case (phase)
        1: begin
          vc = 0;
          tc = 0;
        end
        2: begin
          vc = 1365;
          tc = 8;
        end
        default: begin
          vc = $urandom_range(1) ? $urandom_range(1, 16) : $urandom_range(1, 1365);
          tc = ($urandom_range(3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
        end
      endcase
      configure(vc, tc);

      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        case ($urandom_range(99)) inside
          [0:14]:  load_target();
          [15:24]: load_element($urandom_range(NUM_TARGETS - 1),
                                $urandom_range(NUM_ELEMENTS - 1), pick_value(),
                                1'($urandom_range(1)));
          [25:39]: set_weight($urandom_range(NUM_TARGETS - 1), pick_weight());
          [40:92]: read_component();
          [93:95]: push_request(MODE_SPARE, 3'($urandom()), 12'($urandom()),
                                $urandom(), 1'($urandom()));
          default: wait_drained();
        endcase
      end
    end

    wait_drained();
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
